// ----- rtl/core/bbrcc_pkg.sv -----
// ----------------------------------------------------------------------------
// BBR congestion controller package
// Shared types, codes and constants of the controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bbrcc_pkg;

  // Event codes of an input item
  localparam logic [1:0] CMD_SENT = 2'd0;
  localparam logic [1:0] CMD_ACK  = 2'd1;
  localparam logic [1:0] CMD_LOST = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_FILTER_WINDOW = 3'd0;
  localparam logic [2:0] REG_PRTT_HOLD     = 3'd1;
  localparam logic [2:0] REG_STARTUP_DL    = 3'd2;
  localparam logic [2:0] REG_FLOOR_CWND    = 3'd3;
  localparam logic [2:0] REG_PRTT_CWND     = 3'd4;

  // Configuration reset values
  localparam logic [31:0] RST_FILTER_WINDOW = 32'd10000;
  localparam logic [31:0] RST_PRTT_HOLD     = 32'd200;
  localparam logic [31:0] RST_STARTUP_DL    = 32'd2000;
  localparam logic [23:0] RST_FLOOR_CWND    = 24'd14000;
  localparam logic [23:0] RST_PRTT_CWND     = 24'd5600;

  // State reset values
  localparam logic [6:0]  RST_SRTT    = 7'd50;
  localparam logic [23:0] RST_SBW     = 24'd5242880;
  localparam logic [7:0]  RST_MIN_RTT = 8'd255;
  localparam logic [25:0] RST_PACING  = 26'd10485760;

  // Q2.8 gains
  localparam logic [9:0] GAIN_STARTUP    = 10'd738;
  localparam logic [9:0] GAIN_DRAIN_PACE = 10'd88;
  localparam logic [9:0] GAIN_PBW_CWND   = 10'd512;
  localparam logic [9:0] GAIN_UNIT       = 10'd256;
  localparam logic [9:0] GAIN_UP         = 10'd320;
  localparam logic [9:0] GAIN_DOWN       = 10'd192;

  // Arithmetic constants
  localparam logic [6:0]  RTT_FLOOR  = 7'd10;
  localparam logic [7:0]  TARGET_DIV = 8'd125;
  localparam logic [23:0] MAX24      = 24'hFFFFFF;
  localparam logic [31:0] MAX32      = 32'hFFFFFFFF;
  localparam int          DIV_STEPS  = 16;

  typedef enum logic [1:0] {
    PH_STARTUP   = 2'd0,
    PH_DRAIN     = 2'd1,
    PH_PROBE_BW  = 2'd2,
    PH_PROBE_RTT = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_MOD_STEP,
    OP_RTT,
    OP_DIV_STEP,
    OP_BW,
    OP_FILT,
    OP_MDRN,
    OP_PHASE,
    OP_MCG,
    OP_MRTT,
    OP_PACE,
    OP_CWND,
    OP_OUT
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_RTT,
    ST_DIVS,
    ST_BW,
    ST_FILT,
    ST_MDRN,
    ST_PHASE,
    ST_MCG,
    ST_MRTT,
    ST_PACE,
    ST_DIVT,
    ST_CWND,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e op;
  } ctl_t;

  typedef struct packed {
    logic is_ack;
  } stat_t;

  // Pacing gain of each probe bandwidth slot
  function automatic logic [9:0] cycle_gain(input logic [2:0] slot);
    logic [9:0] g;
    case (slot)
      3'd0:    g = GAIN_UP;
      3'd1:    g = GAIN_DOWN;
      default: g = GAIN_UNIT;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bbrcc_ctrl.sv -----
// ----------------------------------------------------------------------------
// BBR controller sequencer
// Steps the datapath through one item: accept, then for an ack the
// remainder, divide, filter, phase, gain and window steps, then output.
// ----------------------------------------------------------------------------
`default_nettype none

module bbrcc_ctrl #(
  parameter int TIME_BITS = 48
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  input  bbrcc_pkg::stat_t     stat_i,
  output bbrcc_pkg::ctl_t      ctl_o
);
  import bbrcc_pkg::*;

  localparam int NIB = (TIME_BITS + 3) / 4;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !(out_valid_q && out_stall_i);

  // Next state and step counter
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          state_d = stat_i.is_ack ? ST_MOD : ST_DONE;
        end
      end
      ST_MOD: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(NIB - 1)) begin
          cnt_d   = '0;
          state_d = ST_RTT;
        end
      end
      ST_RTT: state_d = ST_DIVS;
      ST_DIVS: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_BW;
        end
      end
      ST_BW:    state_d = ST_FILT;
      ST_FILT:  state_d = ST_MDRN;
      ST_MDRN:  state_d = ST_PHASE;
      ST_PHASE: state_d = ST_MCG;
      ST_MCG:   state_d = ST_MRTT;
      ST_MRTT:  state_d = ST_PACE;
      ST_PACE:  state_d = ST_DIVT;
      ST_DIVT: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_CWND;
        end
      end
      ST_CWND: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands and handshake outputs
  always_comb begin
    ctl_o.op    = OP_NONE;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) ctl_o.op = OP_ACCEPT;
      end
      ST_MOD:   ctl_o.op = OP_MOD_STEP;
      ST_RTT:   ctl_o.op = OP_RTT;
      ST_DIVS:  ctl_o.op = OP_DIV_STEP;
      ST_BW:    ctl_o.op = OP_BW;
      ST_FILT:  ctl_o.op = OP_FILT;
      ST_MDRN:  ctl_o.op = OP_MDRN;
      ST_PHASE: ctl_o.op = OP_PHASE;
      ST_MCG:   ctl_o.op = OP_MCG;
      ST_MRTT:  ctl_o.op = OP_MRTT;
      ST_PACE:  ctl_o.op = OP_PACE;
      ST_DIVT:  ctl_o.op = OP_DIV_STEP;
      ST_CWND:  ctl_o.op = OP_CWND;
      ST_DONE: begin
        if (out_free) begin
          ctl_o.op    = OP_OUT;
          out_valid_d = 1'b1;
        end
      end
      default: ctl_o.op = OP_NONE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/core/bbrcc_dpath.sv -----
// ----------------------------------------------------------------------------
// BBR controller datapath
// Estimator state, a shared radix-4 divider, the remainder unit for the
// RTT sample and the phase, gain and window arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module bbrcc_dpath #(
  parameter int TIME_BITS = 48
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  bbrcc_pkg::ctl_t      ctl_i,
  output bbrcc_pkg::stat_t     stat_o,
  input  wire [1:0]            cmd_i,
  input  wire [15:0]           size_bytes_i,
  input  wire [TIME_BITS-1:0]  now_ms_i,
  input  wire [31:0]           filter_window_i,
  input  wire [31:0]           prtt_hold_i,
  input  wire [31:0]           startup_dl_i,
  input  wire [23:0]           floor_cwnd_i,
  input  wire [23:0]           prtt_cwnd_i,
  output logic [23:0]          cwnd_bytes_o,
  output logic [25:0]          pacing_bytes_per_s_o,
  output logic [1:0]           phase_o,
  output logic [31:0]          inflight_bytes_o
);
  import bbrcc_pkg::*;

  localparam int NIB = (TIME_BITS + 3) / 4;
  localparam int PW  = NIB * 4;

  // Estimator state
  phase_e                phase_q;
  logic [6:0]            srtt_q;
  logic [23:0]           sbw_q;
  logic [7:0]            min_rtt_q;
  logic [TIME_BITS-1:0]  min_rtt_time_q;
  logic [23:0]           max_bw_q;
  logic [TIME_BITS-1:0]  max_bw_time_q;
  logic [25:0]           pacing_q;
  logic [23:0]           cwnd_q;
  logic [31:0]           inflight_q;
  logic [2:0]            slot_q;
  logic [TIME_BITS-1:0]  slot_time_q;
  logic [23:0]           prev_bw_q;
  logic [7:0]            plateau_q;

  // Working registers
  logic [TIME_BITS-1:0]  now_q;
  logic [15:0]           size_q;
  logic [PW-1:0]         mod_sh_q;
  logic [6:0]            mod_rem_q;
  logic [31:0]           div_q;
  logic [7:0]            div_rem_q;
  logic [7:0]            dvs_q;
  logic [41:0]           prod_q;

  // Output register
  logic [23:0]           o_cwnd_q;
  logic [25:0]           o_pacing_q;
  logic [1:0]            o_phase_q;
  logic [31:0]           o_inflight_q;

  assign stat_o.is_ack = (cmd_i == CMD_ACK);

  // Remainder by 100, one nibble per step
  logic [10:0] mod_v, mod_sub;
  always_comb begin
    mod_v   = 11'({mod_rem_q, 4'b0000}) + 11'(mod_sh_q[PW-1 -: 4]);
    mod_sub = '0;
    for (int j = 1; j < 16; j++) begin
      if (mod_v >= 11'(j * 100)) mod_sub = 11'(j * 100);
    end
  end

  // Radix-4 divider step
  logic [9:0] r4, d1, d2, d3;
  logic [1:0] qd;
  logic [9:0] r_next;
  always_comb begin
    r4 = {div_rem_q, div_q[31:30]};
    d1 = 10'(dvs_q);
    d2 = {d1[8:0], 1'b0};
    d3 = d1 + d2;
    if (r4 >= d3) begin
      qd = 2'd3; r_next = r4 - d3;
    end else if (r4 >= d2) begin
      qd = 2'd2; r_next = r4 - d2;
    end else if (r4 >= d1) begin
      qd = 2'd1; r_next = r4 - d1;
    end else begin
      qd = 2'd0; r_next = r4;
    end
  end

  // RTT smoothing
  logic [9:0] rtt_sum;
  logic [6:0] srtt_new;
  assign rtt_sum  = 10'({srtt_q, 3'b000}) - 10'(srtt_q) + 10'(mod_rem_q);
  assign srtt_new = rtt_sum[9:3];

  // Bandwidth smoothing
  logic [29:0] bw_sum;
  assign bw_sum = 30'({sbw_q, 5'b00000}) - 30'(sbw_q) + 30'(div_q);

  // Filter expiry
  logic [TIME_BITS-1:0] d_min, d_max, d_slot;
  logic [6:0]           rtt_s;
  logic                 exp_min, exp_max, hold_done;
  always_comb begin
    d_min     = now_q - min_rtt_time_q;
    d_max     = now_q - max_bw_time_q;
    d_slot    = now_q - slot_time_q;
    rtt_s     = (srtt_q > RTT_FLOOR) ? srtt_q : RTT_FLOOR;
    exp_min   = d_min > TIME_BITS'(filter_window_i);
    exp_max   = d_max > TIME_BITS'(filter_window_i);
    hold_done = d_min > TIME_BITS'(prtt_hold_i);
  end

  // Phase tests
  logic       plateau;
  logic [7:0] plat_next;
  logic       drained;
  always_comb begin
    plateau   = 27'({max_bw_q, 2'b00}) <= (27'({prev_bw_q, 2'b00}) + 27'(prev_bw_q));
    plat_next = plateau ? ((plateau_q == 8'hFF) ? plateau_q : plateau_q + 8'd1) : 8'd0;
    drained   = (42'(inflight_q) * 42'd1000) <= prod_q;
  end

  // Gains
  logic [9:0] pg, cg;
  always_comb begin
    unique case (phase_q)
      PH_STARTUP:  begin pg = GAIN_STARTUP;       cg = GAIN_STARTUP;  end
      PH_DRAIN:    begin pg = GAIN_DRAIN_PACE;    cg = GAIN_STARTUP;  end
      PH_PROBE_BW: begin pg = cycle_gain(slot_q); cg = GAIN_PBW_CWND; end
      default:     begin pg = GAIN_UNIT;          cg = GAIN_UNIT;     end
    endcase
  end

  logic [33:0] pace_prod;
  assign pace_prod = 34'(max_bw_q) * 34'(pg);

  // Window target
  logic [31:0] tgt;
  always_comb begin
    tgt = (phase_q == PH_PROBE_RTT) ? 32'(prtt_cwnd_i) : div_q;
    if (tgt < 32'(floor_cwnd_i)) tgt = 32'(floor_cwnd_i);
  end

  // Sent adjustment of in-flight
  logic [32:0] inf_sum;
  assign inf_sum = 33'(inflight_q) + 33'(size_bytes_i);

  // Advance estimator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_STARTUP;
      srtt_q         <= RST_SRTT;
      sbw_q          <= RST_SBW;
      min_rtt_q      <= RST_MIN_RTT;
      min_rtt_time_q <= '0;
      max_bw_q       <= '0;
      max_bw_time_q  <= '0;
      pacing_q       <= RST_PACING;
      cwnd_q         <= RST_FLOOR_CWND;
      inflight_q     <= '0;
      slot_q         <= '0;
      slot_time_q    <= '0;
      prev_bw_q      <= '0;
      plateau_q      <= '0;
    end else begin
      case (ctl_i.op)
        OP_ACCEPT: begin
          if (cmd_i == CMD_SENT) begin
            inflight_q <= inf_sum[32] ? MAX32 : inf_sum[31:0];
          end else if (cmd_i == CMD_ACK || cmd_i == CMD_LOST) begin
            inflight_q <= (inflight_q >= 32'(size_bytes_i)) ?
                          inflight_q - 32'(size_bytes_i) : 32'd0;
          end
        end
        OP_RTT: srtt_q <= srtt_new;
        OP_BW:  sbw_q  <= (bw_sum[29:5] > 25'(MAX24)) ? MAX24 : bw_sum[28:5];
        OP_FILT: begin
          if (8'(rtt_s) < min_rtt_q || exp_min) begin
            min_rtt_q      <= 8'(rtt_s);
            min_rtt_time_q <= now_q;
          end
          if (sbw_q >= max_bw_q || exp_max) begin
            max_bw_q      <= sbw_q;
            max_bw_time_q <= now_q;
          end
        end
        OP_PHASE: begin
          unique case (phase_q)
            PH_STARTUP: begin
              plateau_q <= plat_next;
              prev_bw_q <= max_bw_q;
              if (plat_next >= 8'd3 || now_q > TIME_BITS'(startup_dl_i)) begin
                phase_q <= PH_DRAIN;
              end
            end
            PH_DRAIN: begin
              if (drained) begin
                phase_q     <= PH_PROBE_BW;
                slot_q      <= '0;
                slot_time_q <= now_q;
              end
            end
            PH_PROBE_BW: begin
              if (d_slot > TIME_BITS'(min_rtt_q)) begin
                slot_q      <= slot_q + 3'd1;
                slot_time_q <= now_q;
              end
              if (exp_min) phase_q <= PH_PROBE_RTT;
            end
            default: begin
              if (hold_done) begin
                phase_q     <= PH_PROBE_BW;
                slot_q      <= '0;
                slot_time_q <= now_q;
              end
            end
          endcase
        end
        OP_PACE: pacing_q <= pace_prod[33:8];
        OP_CWND: cwnd_q   <= (tgt > 32'(MAX24)) ? MAX24 : tgt[23:0];
        default: ;
      endcase
    end
  end

  // Advance working registers
  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      OP_ACCEPT: begin
        now_q     <= now_ms_i;
        size_q    <= size_bytes_i;
        mod_sh_q  <= PW'(now_ms_i);
        mod_rem_q <= '0;
      end
      OP_MOD_STEP: begin
        mod_rem_q <= 7'(mod_v - mod_sub);
        mod_sh_q  <= mod_sh_q << 4;
      end
      OP_RTT: begin
        div_q     <= 32'(size_q) * 32'd1000;
        div_rem_q <= '0;
        dvs_q     <= (srtt_new == 7'd0) ? 8'd1 : 8'(srtt_new);
      end
      OP_DIV_STEP: begin
        div_q     <= {div_q[29:0], qd};
        div_rem_q <= r_next[7:0];
      end
      OP_MDRN: prod_q <= 42'(32'(max_bw_q) * 32'(min_rtt_q));
      OP_MCG:  prod_q <= 42'(34'(max_bw_q) * 34'(cg));
      OP_MRTT: prod_q <= 42'(prod_q[33:0]) * 42'(min_rtt_q);
      OP_PACE: begin
        div_q     <= 32'(prod_q[41:11]);
        div_rem_q <= '0;
        dvs_q     <= TARGET_DIV;
      end
      OP_OUT: begin
        o_cwnd_q     <= cwnd_q;
        o_pacing_q   <= pacing_q;
        o_phase_q    <= phase_q;
        o_inflight_q <= inflight_q;
      end
      default: ;
    endcase
  end

  assign cwnd_bytes_o         = o_cwnd_q;
  assign pacing_bytes_per_s_o = o_pacing_q;
  assign phase_o              = o_phase_q;
  assign inflight_bytes_o     = o_inflight_q;

endmodule

`default_nettype wire

// ----- rtl/core/bbr_congestion_control.sv -----
// ----------------------------------------------------------------------------
// BBR congestion controller
// Simplified BBR: in-flight accounting, RTT and bandwidth estimators,
// windowed filters, phase machine, pacing rate and congestion window.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one event item: cmd_i,
//   size_bytes_i, now_ms_i. Output channel (out_valid_o / out_stall_i)
//   returns one result item per event: window, pacing rate, phase, in-flight.
//   Items are taken one at a time. A sent, lost or unknown event goes from
//   acceptance straight to its result. An ack first takes the time modulo
//   100 one nibble per cycle, then divides for the bandwidth sample, runs
//   the filter, phase, gain and pacing steps, divides for the window target
//   on the same shared radix-4 divider and sets the window.
//   A result sits in an output register; the next item is accepted while it
//   waits, and a stalled result holds until taken. A finished item waits
//   for the output register to free before its result is loaded.
//   Reset clears the estimator state to its initial values and loads the
//   configuration registers with defaults. The user writes configuration
//   over the APB port only while no item is in progress; it is not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module bbr_congestion_control #(
  parameter int TIME_BITS = 48
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // Event channel
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire [1:0]            cmd_i,
  input  wire [15:0]           size_bytes_i,
  input  wire [TIME_BITS-1:0]  now_ms_i,
  // Result channel
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic [23:0]          cwnd_bytes_o,
  output logic [25:0]          pacing_bytes_per_s_o,
  output logic [1:0]           phase_o,
  output logic [31:0]          inflight_bytes_o,
  // Configuration port
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire [4:0]            paddr,
  input  wire [31:0]           pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import bbrcc_pkg::*;

  logic [31:0] filter_window_q;
  logic [31:0] prtt_hold_q;
  logic [31:0] startup_dl_q;
  logic [23:0] floor_cwnd_q;
  logic [23:0] prtt_cwnd_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  ctl_t        ctl;
  stat_t       stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_window_q <= RST_FILTER_WINDOW;
      prtt_hold_q     <= RST_PRTT_HOLD;
      startup_dl_q    <= RST_STARTUP_DL;
      floor_cwnd_q    <= RST_FLOOR_CWND;
      prtt_cwnd_q     <= RST_PRTT_CWND;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FILTER_WINDOW: filter_window_q <= pwdata;
        REG_PRTT_HOLD:     prtt_hold_q     <= pwdata;
        REG_STARTUP_DL:    startup_dl_q    <= pwdata;
        REG_FLOOR_CWND:    floor_cwnd_q    <= pwdata[23:0];
        REG_PRTT_CWND:     prtt_cwnd_q     <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Read back configuration
  always_comb begin
    unique case (cfg_idx)
      REG_FILTER_WINDOW: prdata = filter_window_q;
      REG_PRTT_HOLD:     prdata = prtt_hold_q;
      REG_STARTUP_DL:    prdata = startup_dl_q;
      REG_FLOOR_CWND:    prdata = 32'(floor_cwnd_q);
      REG_PRTT_CWND:     prdata = 32'(prtt_cwnd_q);
      default:           prdata = '0;
    endcase
  end

  bbrcc_ctrl #(
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  bbrcc_dpath #(
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .ctl_i                (ctl),
    .stat_o               (stat),
    .cmd_i                (cmd_i),
    .size_bytes_i         (size_bytes_i),
    .now_ms_i             (now_ms_i),
    .filter_window_i      (filter_window_q),
    .prtt_hold_i          (prtt_hold_q),
    .startup_dl_i         (startup_dl_q),
    .floor_cwnd_i         (floor_cwnd_q),
    .prtt_cwnd_i          (prtt_cwnd_q),
    .cwnd_bytes_o         (cwnd_bytes_o),
    .pacing_bytes_per_s_o (pacing_bytes_per_s_o),
    .phase_o              (phase_o),
    .inflight_bytes_o     (inflight_bytes_o)
  );

  // One item at a time: an accepted item closes the input
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not closed after accepting an item");

  // A fresh result comes with the input open again
  a_idle_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result shown while item still in progress");

  // A new result only follows a cycle in which work was going on
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in progress");

endmodule

`default_nettype wire
